FILE: hdl/spq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies; imported by spq_cell, sorted_priority_queue, spq_checker and tb_top
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] NO_DATA = {DATA_W{1'b1}};

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of CAPACITY cells kept in service
// order. Each transfer on the input is an enqueue (s_tuser = 0) or a dequeue
// (s_tuser = 1) and gives exactly one result transfer. Every cell compares the
// new priority against its own entry in the same cycle, so an insert or a
// shift-out updates all cells at once and its result is in the output register on
// the next cycle. An input transfer is taken while that register is empty or
// in the same cycle its result leaves, so one operation per cycle is sustained
// while m_tready stays high; the input stalls only while a result waits on a
// low m_tready. Smaller priority values leave first, equal ones in arrival order;
// an enqueue into a full queue is refused with status full.
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // data_in[31:0], priority_in[39:32]
    input  wire logic [0:0]  s_tuser,  // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // data_out[31:0], status[33:32],
                                       // is_empty[34], occupancy[39:35]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg, m_tdata_next;

    logic              accept;
    logic              mode;
    logic              full, empty;
    spq_ctrl_t         ctrl;
    logic [PW-1:0]     new_prio;
    logic [DATA_W-1:0] new_data;
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W+OCC_W-1:0] count_ext;

    logic              cell_gt   [CAPACITY];
    logic [PW-1:0]     cell_prio [CAPACITY];
    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser[0];
    assign new_data = s_tdata[DATA_W-1:0];
    assign new_prio = s_tdata[DATA_W +: PW];

    assign full  = count_reg == CNT_W'(CAPACITY);
    assign empty = count_reg == '0;

    assign ctrl.enq = accept && (mode == MODE_ENQ) && !full;
    assign ctrl.deq = accept && (mode == MODE_DEQ) && !empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic              l_gt;
            logic [PW-1:0]     l_prio, r_prio;
            logic [DATA_W-1:0] l_data, r_data;

            if (g == 0)
            begin : g_head
                assign l_gt   = 1'b0;
                assign l_prio = new_prio;
                assign l_data = new_data;
            end
            else
            begin : g_body
                assign l_gt   = cell_gt[g-1];
                assign l_prio = cell_prio[g-1];
                assign l_data = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign r_prio = cell_prio[g];
                assign r_data = cell_data[g];
            end
            else
            begin : g_mid
                assign r_prio = cell_prio[g+1];
                assign r_data = cell_data[g+1];
            end

            spq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W),
                .PW    (PW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .new_prio   (new_prio),
                .new_data   (new_data),
                .left_gt    (l_gt),
                .left_prio  (l_prio),
                .left_data  (l_data),
                .right_prio (r_prio),
                .right_data (r_data),
                .gt         (cell_gt[g]),
                .prio       (cell_prio[g]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        status     = ST_DONE;
        data_out   = NO_DATA;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
            data_out   = cell_data[0];
        end
        else if (mode == MODE_ENQ)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_EMPTY;
        end
    end

    assign count_ext    = {{OCC_W{1'b0}}, count_next};
    assign m_tdata_next = {count_ext[OCC_W-1:0], (count_next == '0), status, data_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: hdl/spq_cell.sv
// one slot of the sorted chain: holds an entry, inserts or shifts on an enqueue or dequeue
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int PW    = 8
) (
    input  wire logic              clk,
    input  wire spq_ctrl_t         ctrl,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [PW-1:0]     new_prio,
    input  wire logic [DATA_W-1:0] new_data,
    input  wire logic              left_gt,
    input  wire logic [PW-1:0]     left_prio,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [PW-1:0]     right_prio,
    input  wire logic [DATA_W-1:0] right_data,
    output logic                   gt,
    output logic [PW-1:0]          prio,
    output logic [DATA_W-1:0]      data
);

    logic [PW-1:0]     prio_reg, prio_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              occupied;

    assign occupied = count > CNT_W'(IDX);
    // strictly greater keeps equal priorities in arrival order
    assign gt = occupied && (prio_reg > new_prio);

    always_comb
    begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (ctrl.enq)
        begin
            if (left_gt)
            begin
                prio_next = left_prio;
                data_next = left_data;
            end
            else if (gt || !occupied)
            begin
                prio_next = new_prio;
                data_next = new_data;
            end
        end
        else if (ctrl.deq)
        begin
            prio_next = right_prio;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign data = data_reg;

endmodule

`default_nettype wire

FILE: tb/spq_checker.sv
// result checker for the sorted priority queue: keeps its own copy of the queue,
// predicts one result per input transfer and compares every output transfer
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [DATA_W+PRIO_W-1:0] s_tdata,  // data_in[31:0], priority_in[39:32]
    input  logic [0:0]               s_tuser,  // mode[0]
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [DATA_W+PRIO_W-1:0] m_tdata,  // data_out[31:0], status[33:32],
                                               // is_empty[34], occupancy[39:35]
    output int                       mismatches,
    output int                       pending
);

    // laid out so that the packed struct matches m_tdata bit for bit
    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic [1:0]        status;
        logic [DATA_W-1:0] data;
    } queue_result_t;

    logic [DATA_W-1:0] held_data [CAPACITY];
    logic [PRIO_W-1:0] held_prio [CAPACITY];
    int                held_count = 0;
    queue_result_t     due_results [$];
    int                error_count = 0;
    int                due_count = 0;

    assign mismatches = error_count;
    assign pending    = due_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] queue mismatch: %s", $time, what);
        error_count++;
    endtask

    // one enqueue or dequeue on the local copy, returns the result it gives
    task automatic apply_queue_op(
        input  logic              mode,
        input  logic [DATA_W-1:0] word,
        input  logic [PRIO_W-1:0] prio,
        output queue_result_t     res
    );
        int                slot;
        logic [PRIO_W-1:0] key;
        key = prio;
        for (int b = PRIORITY_BITS; b < PRIO_W; b++)
            key[b] = 1'b0;
        res.data   = NO_DATA;
        res.status = ST_DONE;
        if (mode == MODE_ENQ)
        begin
            if (held_count >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                // new entry goes behind every entry of equal or smaller priority
                slot = 0;
                while (slot < held_count && held_prio[slot] <= key)
                    slot++;
                for (int i = held_count; i > slot; i--)
                begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[slot] = word;
                held_prio[slot] = key;
                held_count++;
            end
        end
        else if (held_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            res.data = held_data[0];
            for (int i = 1; i < held_count; i++)
            begin
                held_data[i-1] = held_data[i];
                held_prio[i-1] = held_prio[i];
            end
            held_count--;
        end
        res.is_empty  = (held_count == 0);
        res.occupancy = held_count[OCC_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t fresh;
        queue_result_t want;
        queue_result_t got;
        if (!rst_n)
        begin
            held_count = 0;
            due_results.delete();
            due_count <= 0;
        end
        else
        begin
            // push before pop so a same-cycle result would still find its entry
            if (s_tvalid && s_tready)
            begin
                apply_queue_op(s_tuser[0], s_tdata[DATA_W-1:0],
                               s_tdata[DATA_W+PRIO_W-1:DATA_W], fresh);
                due_results.push_back(fresh);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (due_results.size() == 0)
                    report_mismatch($sformatf("result %h with nothing due", m_tdata));
                else
                begin
                    want = due_results.pop_front();
                    if (got.data !== want.data)
                        report_mismatch($sformatf("data_out %h, expected %h",
                                                  got.data, want.data));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  got.is_empty, want.is_empty));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  got.occupancy, want.occupancy));
                end
            end
            due_count <= due_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// top of the sorted priority queue testbench: clock, reset, stimulus, output
// back-pressure, stall watchdog and verdict; depends on spq_pkg,
// sorted_priority_queue and spq_checker
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int PRIORITY_BITS    = 8;
    localparam int RANDOM_PER_PHASE = 384;
    // one item per cycle while m_tready stays high; STALL_LIMIT silent cycles mean the block is stuck
    localparam int STALL_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 16;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [DATA_W+PRIO_W-1:0] s_tdata = '0;  // data_in[31:0], priority_in[39:32]
    logic [0:0]               s_tuser = '0;  // mode[0]
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [DATA_W+PRIO_W-1:0] m_tdata;       // data_out[31:0], status[33:32],
                                             // is_empty[34], occupancy[39:35]
    int                       mismatches;
    int                       pending;
    int                       tx_idle_pct = 0;
    int                       rx_idle_pct = 0;
    int                       quiet_cycles = 0;

    always #5 clk = ~clk;

    sorted_priority_queue #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spq_checker #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [DATA_W-1:0] pick_word();
        if ($urandom_range(9) != 0)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // often a narrow range so equal priorities pile up
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(9))
            0, 1, 2, 3: return PRIO_W'($urandom_range(3));
            4: return ($urandom_range(1) != 0) ? 8'hff : 8'h00;
            default: return PRIO_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_op(
        input logic              mode,
        input logic [DATA_W-1:0] word,
        input logic [PRIO_W-1:0] prio
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {prio, word};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold the input until every outstanding result has come out
    task automatic wait_results_out();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // bursts with a random enqueue bias so the queue swings between empty and full
    task automatic run_random(input int count);
        int left;
        int burst;
        int enq_pct;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(40, 4);
            case ($urandom_range(3))
                0: enq_pct = 15;
                1: enq_pct = 50;
                2: enq_pct = 85;
                default: enq_pct = 100;
            endcase
            for (int k = 0; k < burst && left > 0; k++)
            begin
                send_op(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
                        pick_word(), pick_prio());
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, extreme words and priorities, ties, then drain past empty
        send_op(MODE_DEQ, 32'h1234_5678, 8'h00);
        send_op(MODE_ENQ, 32'h7fff_ffff, 8'hff);
        send_op(MODE_ENQ, 32'h8000_0000, 8'h00);
        send_op(MODE_ENQ, 32'hffff_ffff, 8'hff);
        send_op(MODE_ENQ, 32'h0000_0000, 8'h00);
        send_op(MODE_ENQ, 32'h5a5a_a5a5, 8'h80);
        send_op(MODE_ENQ, 32'ha5a5_5a5a, 8'h7f);
        repeat (7)
            send_op(MODE_DEQ, 32'hffff_ffff, 8'hff);
        wait_results_out();

        tx_idle_pct <= 18;
        rx_idle_pct <= 57;
        run_random(RANDOM_PER_PHASE / 2);
        wait_results_out();
        run_random(RANDOM_PER_PHASE / 2);

        tx_idle_pct <= 57;
        rx_idle_pct <= 18;
        run_random(RANDOM_PER_PHASE);
        wait_results_out();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        run_random(RANDOM_PER_PHASE);
        wait_results_out();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/tb_top.sv
